[rtl/d2drot_pkg.sv]
package d2drot_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DW        = 16;
	localparam int MAG_W     = 32;
	localparam int LEN_W     = 33;
	localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int SQ_STEPS  = 32;
	localparam int SQ_LAT    = SQ_STEPS + 1;
	localparam int CS_W      = 19;
	localparam int SN_W      = 20;
	localparam int FRONT     = 4;
	localparam int LAT       = FRONT + SQ_LAT + Q_W + 4;

	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic [63:0]        HALF = 64'd1 << (FRAC_BITS - 1);

	typedef struct packed {
		logic [2:0]              neg;
		logic [MAG_W-1:0]        mx;
		logic [MAG_W-1:0]        my;
		logic [MAG_W-1:0]        mz;
		logic signed [CS_W-1:0]  cs;
		logic                    ident;
		logic                    opp;
	} sq_ctx_t;

	typedef struct packed {
		logic [2:0]              neg;
		logic signed [CS_W-1:0]  cs;
		logic signed [SN_W-1:0]  sn;
		logic                    ident;
	} dv_ctx_t;

	function automatic logic signed [63:0] rshr(input logic signed [63:0] v);
		logic [63:0] m;
		m = v < 0 ? 64'(-v) : 64'(v);
		m = (m + HALF) >> FRAC_BITS;
		return v < 0 ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic [DW-1:0] sat_out(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (r > ONE)
			r = ONE;
		if (r < -ONE)
			r = -ONE;
		return DW'(r);
	endfunction

endpackage

[rtl/direction_to_direction_rotation_unit.sv]
// Throughput: one beat per cycle while the output is not stalled; the square root
// takes 33 stages and the three axis dividers 15 stages each, all fully pipelined.
// The whole pipeline advances while the output register is empty or taken.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
module direction_to_direction_rotation_unit import d2drot_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // from_x, from_y, from_z, to_x, to_y, to_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata   // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

	logic en;
	logic [LAT-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
	end

	logic signed [DW-1:0] fx, fy, fz, tx, ty, tz;
	assign fx = s_tdata[15:0];
	assign fy = s_tdata[31:16];
	assign fz = s_tdata[47:32];
	assign tx = s_tdata[63:48];
	assign ty = s_tdata[79:64];
	assign tz = s_tdata[95:80];

	logic signed [31:0] fytz_s1, fzty_s1, fztx_s1, fxtz_s1, fxty_s1, fytx_s1;
	logic signed [31:0] fxtx_s1, fyty_s1, fztz_s1;
	logic signed [DW-1:0] fx_s1, fy_s1, fz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			fytz_s1 <= fy * tz;
			fzty_s1 <= fz * ty;
			fztx_s1 <= fz * tx;
			fxtz_s1 <= fx * tz;
			fxty_s1 <= fx * ty;
			fytx_s1 <= fy * tx;
			fxtx_s1 <= fx * tx;
			fyty_s1 <= fy * ty;
			fztz_s1 <= fz * tz;
			fx_s1   <= fx;
			fy_s1   <= fy;
			fz_s1   <= fz;
		end
	end

	logic signed [32:0] cx_s2, cy_s2, cz_s2, dot_s2;
	logic signed [16:0] ox_s2, oy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2  <= 33'(fytz_s1) - 33'(fzty_s1);
			cy_s2  <= 33'(fztx_s1) - 33'(fxtz_s1);
			cz_s2  <= 33'(fxty_s1) - 33'(fytx_s1);
			dot_s2 <= 33'(fxtx_s1) + 33'(fyty_s1) + 33'(fztz_s1);
			if (fx_s1 != 0 || fy_s1 != 0) begin
				ox_s2 <= 17'(fy_s1);
				oy_s2 <= -17'(fx_s1);
			end else begin
				ox_s2 <= 17'(fz_s1);
				oy_s2 <= '0;
			end
		end
	end

	logic [MAG_W-1:0] mcx, mcy, mcz;
	logic [16:0] mox, moy;
	assign mcx = MAG_W'(cx_s2 < 0 ? -cx_s2 : cx_s2);
	assign mcy = MAG_W'(cy_s2 < 0 ? -cy_s2 : cy_s2);
	assign mcz = MAG_W'(cz_s2 < 0 ? -cz_s2 : cz_s2);
	assign mox = 17'(ox_s2 < 0 ? -ox_s2 : ox_s2);
	assign moy = 17'(oy_s2 < 0 ? -oy_s2 : oy_s2);

	logic [63:0] sqx_s3, sqy_s3, sqz_s3;
	logic [33:0] sox_s3, soy_s3;
	logic [MAG_W-1:0] mcx_s3, mcy_s3, mcz_s3;
	logic [16:0] mox_s3, moy_s3;
	logic [2:0] cneg_s3, oneg_s3;
	logic signed [CS_W-1:0] cs_s3;
	logic dneg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3  <= 64'(mcx) * 64'(mcx);
			sqy_s3  <= 64'(mcy) * 64'(mcy);
			sqz_s3  <= 64'(mcz) * 64'(mcz);
			sox_s3  <= 34'(mox) * 34'(mox);
			soy_s3  <= 34'(moy) * 34'(moy);
			mcx_s3  <= mcx;
			mcy_s3  <= mcy;
			mcz_s3  <= mcz;
			mox_s3  <= mox;
			moy_s3  <= moy;
			cneg_s3 <= {cz_s2 < 0, cy_s2 < 0, cx_s2 < 0};
			oneg_s3 <= {1'b0, oy_s2 < 0, ox_s2 < 0};
			cs_s3   <= CS_W'(rshr(dot_s2));
			dneg_s3 <= dot_s2 < 0;
		end
	end

	logic [63:0] len2_s4;
	logic [34:0] ol2_s4;
	logic [MAG_W-1:0] mcx_s4, mcy_s4, mcz_s4;
	logic [16:0] mox_s4, moy_s4;
	logic [2:0] cneg_s4, oneg_s4;
	logic signed [CS_W-1:0] cs_s4;
	logic dneg_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			len2_s4 <= sqx_s3 + sqy_s3 + sqz_s3;
			ol2_s4  <= 35'(sox_s3) + 35'(soy_s3);
			mcx_s4  <= mcx_s3;
			mcy_s4  <= mcy_s3;
			mcz_s4  <= mcz_s3;
			mox_s4  <= mox_s3;
			moy_s4  <= moy_s3;
			cneg_s4 <= cneg_s3;
			oneg_s4 <= oneg_s3;
			cs_s4   <= cs_s3;
			dneg_s4 <= dneg_s3;
		end
	end

	logic zero4, opp4;
	logic [63:0] rad;
	sq_ctx_t sq_in;

	assign zero4 = len2_s4 == 0;
	assign opp4  = zero4 && dneg_s4;

	always_comb begin
		sq_in.cs    = cs_s4;
		sq_in.ident = zero4 && !dneg_s4;
		sq_in.opp   = opp4;
		if (opp4) begin
			rad      = 64'(ol2_s4);
			sq_in.neg = oneg_s4;
			sq_in.mx = MAG_W'(mox_s4);
			sq_in.my = MAG_W'(moy_s4);
			sq_in.mz = '0;
		end else begin
			rad      = len2_s4;
			sq_in.neg = cneg_s4;
			sq_in.mx = mcx_s4;
			sq_in.my = mcy_s4;
			sq_in.mz = mcz_s4;
		end
	end

	logic [LEN_W-1:0] len;
	sq_ctx_t sq_ctx_q [0:SQ_LAT-1];

	d2drot_sqrt u_sqrt (
		.clk (clk),
		.en  (en),
		.rad (rad),
		.len (len)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_ctx_q[0] <= sq_in;
			for (int i = 1; i < SQ_LAT; i++)
				sq_ctx_q[i] <= sq_ctx_q[i-1];
		end
	end

	sq_ctx_t sq_out;
	dv_ctx_t dv_in;
	logic [NUM_W-1:0] numx, numy, numz, lhalf;

	assign sq_out = sq_ctx_q[SQ_LAT-1];
	assign lhalf  = NUM_W'(len >> 1);
	assign numx   = (NUM_W'(sq_out.mx) << FRAC_BITS) + lhalf;
	assign numy   = (NUM_W'(sq_out.my) << FRAC_BITS) + lhalf;
	assign numz   = (NUM_W'(sq_out.mz) << FRAC_BITS) + lhalf;

	always_comb begin
		dv_in.neg   = sq_out.neg;
		dv_in.cs    = sq_out.cs;
		dv_in.ident = sq_out.ident;
		dv_in.sn    = sq_out.opp ? '0 : SN_W'(rshr(64'(len)));
	end

	logic [Q_W-1:0] qx, qy, qz;

	d2drot_div u_divx (.clk(clk), .en(en), .num(numx), .den(len), .q(qx));
	d2drot_div u_divy (.clk(clk), .en(en), .num(numy), .den(len), .q(qy));
	d2drot_div u_divz (.clk(clk), .en(en), .num(numz), .den(len), .q(qz));

	dv_ctx_t dv_ctx_q [0:Q_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ctx_q[0] <= dv_in;
			for (int i = 1; i < Q_W; i++)
				dv_ctx_q[i] <= dv_ctx_q[i-1];
		end
	end

	dv_ctx_t dv_out;
	logic [Q_W-1:0] cqx, cqy, cqz;
	localparam logic [Q_W-1:0] QONE = Q_W'(ONE);

	assign dv_out = dv_ctx_q[Q_W-1];
	assign cqx = qx > QONE ? QONE : qx;
	assign cqy = qy > QONE ? QONE : qy;
	assign cqz = qz > QONE ? QONE : qz;

	logic signed [DW-1:0] nx_s5, ny_s5, nz_s5;
	logic signed [SN_W-1:0] omc_s5, sn_s5;
	logic signed [CS_W-1:0] cs_s5;
	logic ident_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5    <= dv_out.neg[0] ? -DW'(cqx) : DW'(cqx);
			ny_s5    <= dv_out.neg[1] ? -DW'(cqy) : DW'(cqy);
			nz_s5    <= dv_out.neg[2] ? -DW'(cqz) : DW'(cqz);
			omc_s5   <= SN_W'(ONE) - SN_W'(dv_out.cs);
			sn_s5    <= dv_out.sn;
			cs_s5    <= dv_out.cs;
			ident_s5 <= dv_out.ident;
		end
	end

	logic signed [DW-1:0] pxx_s6, pyy_s6, pzz_s6, pxy_s6, pxz_s6, pyz_s6;
	logic signed [20:0] sx_s6, sy_s6, sz_s6;
	logic signed [SN_W-1:0] omc_s6;
	logic signed [CS_W-1:0] cs_s6;
	logic ident_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s6   <= DW'(rshr(nx_s5 * nx_s5));
			pyy_s6   <= DW'(rshr(ny_s5 * ny_s5));
			pzz_s6   <= DW'(rshr(nz_s5 * nz_s5));
			pxy_s6   <= DW'(rshr(nx_s5 * ny_s5));
			pxz_s6   <= DW'(rshr(nx_s5 * nz_s5));
			pyz_s6   <= DW'(rshr(ny_s5 * nz_s5));
			sx_s6    <= 21'(rshr(nx_s5 * sn_s5));
			sy_s6    <= 21'(rshr(ny_s5 * sn_s5));
			sz_s6    <= 21'(rshr(nz_s5 * sn_s5));
			omc_s6   <= omc_s5;
			cs_s6    <= cs_s5;
			ident_s6 <= ident_s5;
		end
	end

	logic signed [20:0] xx_s7, yy_s7, zz_s7, xy_s7, xz_s7, yz_s7;
	logic signed [20:0] sx_s7, sy_s7, sz_s7;
	logic signed [CS_W-1:0] cs_s7;
	logic ident_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s7    <= 21'(rshr(pxx_s6 * omc_s6));
			yy_s7    <= 21'(rshr(pyy_s6 * omc_s6));
			zz_s7    <= 21'(rshr(pzz_s6 * omc_s6));
			xy_s7    <= 21'(rshr(pxy_s6 * omc_s6));
			xz_s7    <= 21'(rshr(pxz_s6 * omc_s6));
			yz_s7    <= 21'(rshr(pyz_s6 * omc_s6));
			sx_s7    <= sx_s6;
			sy_s7    <= sy_s6;
			sz_s7    <= sz_s6;
			cs_s7    <= cs_s6;
			ident_s7 <= ident_s6;
		end
	end

	localparam logic [DW-1:0] EONE = DW'(ONE);

	always_ff @(posedge clk) begin
		if (en) begin
			if (ident_s7) begin
				m_tdata <= {EONE, {DW{1'b0}}, {DW{1'b0}},
					{DW{1'b0}}, EONE, {DW{1'b0}},
					{DW{1'b0}}, {DW{1'b0}}, EONE};
			end else begin
				m_tdata[15:0]    <= sat_out(xx_s7 + cs_s7);
				m_tdata[31:16]   <= sat_out(xy_s7 + sz_s7);
				m_tdata[47:32]   <= sat_out(xz_s7 - sy_s7);
				m_tdata[63:48]   <= sat_out(xy_s7 - sz_s7);
				m_tdata[79:64]   <= sat_out(yy_s7 + cs_s7);
				m_tdata[95:80]   <= sat_out(yz_s7 + sx_s7);
				m_tdata[111:96]  <= sat_out(xz_s7 + sy_s7);
				m_tdata[127:112] <= sat_out(yz_s7 - sx_s7);
				m_tdata[143:128] <= sat_out(zz_s7 + cs_s7);
			end
		end
	end

endmodule

[rtl/d2drot_sqrt.sv]
module d2drot_sqrt import d2drot_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [63:0]      rad,
	output logic [LEN_W-1:0] len
);

	logic [63:0] y_s [0:SQ_STEPS];
	logic [63:0] r_s [0:SQ_STEPS];

	assign y_s[0] = rad;
	assign r_s[0] = '0;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] t;
		assign t = r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[k] >= t) begin
					y_s[k+1] <= y_s[k] - t;
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					y_s[k+1] <= y_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			len <= LEN_W'(r_s[SQ_STEPS] + 64'(y_s[SQ_STEPS] > r_s[SQ_STEPS]));
	end

endmodule

[rtl/d2drot_div.sv]
module d2drot_div import d2drot_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [LEN_W-1:0] den,
	output logic [Q_W-1:0]   q
);

	logic [NUM_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic [LEN_W-1:0] den_s [0:Q_W];

	assign rem_s[0] = num;
	assign q_s[0]   = '0;
	assign den_s[0] = den;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int B = Q_W - 1 - k;
		logic [NUM_W-1:0] dsh;
		assign dsh = NUM_W'(den_s[k]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1] <= den_s[k];
				if (rem_s[k] >= dsh) begin
					rem_s[k+1] <= rem_s[k] - dsh;
					q_s[k+1]   <= q_s[k] | (Q_W'(1) << B);
				end else begin
					rem_s[k+1] <= rem_s[k];
					q_s[k+1]   <= q_s[k];
				end
			end
		end
	end

	assign q = q_s[Q_W];

endmodule

[rtl/d2drot_chk.sv]
module d2drot_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [95:0]  s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed under stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_diag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384
			&& $signed(m_tdata[79:64]) <= 16384 && $signed(m_tdata[79:64]) >= -16384
			&& $signed(m_tdata[143:128]) <= 16384 && $signed(m_tdata[143:128]) >= -16384)
		else $error("diagonal element outside saturation range");

	a_offd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384
			&& $signed(m_tdata[95:80]) <= 16384 && $signed(m_tdata[95:80]) >= -16384)
		else $error("off-diagonal element outside saturation range");

endmodule

bind direction_to_direction_rotation_unit d2drot_chk u_chk (.*);

[bench/direction_to_direction_rotation_unit_test.sv]
`timescale 1ns / 100ps

module direction_to_direction_rotation_unit_test;
	import d2drot_pkg::*;

	typedef struct packed {
		logic signed [15:0] tz, ty, tx, fz, fy, fx;
	} vec_pair_t;

	typedef logic [143:0] matrix_t;

	localparam int ITEMS      = 1200;
	localparam int HOLD_LONG  = 300;
	localparam longint LIMIT  = 400000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;

	vec_pair_t pending_pairs[$];
	matrix_t   expected_matrices[$];
	int        errors;
	int        matrices_seen;
	int        same_dir_cnt;
	bit        stimulus_done;
	bit        drain_request;
	bit        long_hold_done;
	bit        in_acc;
	int        send_gap;
	int        recv_gap;
	int        hold_count;
	longint    cycle_count;

	direction_to_direction_rotation_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint round_q(longint v);
		longint h;
		h = longint'(1) << (FRAC_BITS - 1);
		if (v >= 0)
			return (v + h) >>> FRAC_BITS;
		return -((-v + h) >>> FRAC_BITS);
	endfunction

	function automatic longint isqrt_round(longint unsigned x);
		longint unsigned r;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 64'd4294967295;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= x)
				lo = mid;
			else
				hi = mid - 1;
		end
		r = lo;
		if (x - r * r > r)
			r++;
		return longint'(r);
	endfunction

	function automatic longint axis_comp(longint v, longint len);
		longint one;
		longint m;
		longint q;
		one = longint'(1) << FRAC_BITS;
		m = v < 0 ? -v : v;
		q = ((m << FRAC_BITS) + len / 2) / len;
		if (q > one)
			q = one;
		return v < 0 ? -q : q;
	endfunction

	function automatic logic [15:0] clamp_q(longint v);
		longint one;
		one = longint'(1) << FRAC_BITS;
		if (v > one)
			v = one;
		if (v < -one)
			v = -one;
		return v[15:0];
	endfunction

	function automatic matrix_t rotation_between(vec_pair_t p);
		longint one, fx, fy, fz, tx, ty, tz, cx, cy, cz, dot;
		longint unsigned len2, l2;
		longint vx, vy, vz, len, sn, cs, omc, nx, ny, nz;
		longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
		matrix_t m;
		one = longint'(1) << FRAC_BITS;
		fx = p.fx; fy = p.fy; fz = p.fz;
		tx = p.tx; ty = p.ty; tz = p.tz;
		cx = fy * tz - fz * ty;
		cy = fz * tx - fx * tz;
		cz = fx * ty - fy * tx;
		dot = fx * tx + fy * ty + fz * tz;
		len2 = cx * cx + cy * cy + cz * cz;
		if (len2 == 0 && dot >= 0)
			return {clamp_q(one), 16'd0, 16'd0, 16'd0, clamp_q(one), 16'd0,
				16'd0, 16'd0, clamp_q(one)};
		sn = 0;
		if (len2 == 0) begin
			if (fx != 0 || fy != 0) begin
				vx = fy; vy = -fx; vz = 0;
			end else begin
				vx = fz; vy = 0; vz = 0;
			end
			l2 = vx * vx + vy * vy + vz * vz;
		end else begin
			vx = cx; vy = cy; vz = cz;
			l2 = len2;
		end
		len = isqrt_round(l2);
		if (len2 != 0)
			sn = round_q(len);
		nx = axis_comp(vx, len);
		ny = axis_comp(vy, len);
		nz = axis_comp(vz, len);
		cs = round_q(dot);
		omc = one - cs;
		xx = round_q(round_q(nx * nx) * omc);
		yy = round_q(round_q(ny * ny) * omc);
		zz = round_q(round_q(nz * nz) * omc);
		xy = round_q(round_q(nx * ny) * omc);
		xz = round_q(round_q(nx * nz) * omc);
		yz = round_q(round_q(ny * nz) * omc);
		sx = round_q(nx * sn);
		sy = round_q(ny * sn);
		sz = round_q(nz * sn);
		m = {clamp_q(zz + cs), clamp_q(yz - sx), clamp_q(xz + sy),
			clamp_q(yz + sx), clamp_q(yy + cs), clamp_q(xy - sz),
			clamp_q(xz - sy), clamp_q(xy + sz), clamp_q(xx + cs)};
		return m;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic vec_pair_t unit_pair();
		vec_pair_t p;
		real a, b, c, d, n1, n2;
		int sel;
		a = $itor($signed($urandom_range(0, 20000)) - 10000);
		b = $itor($signed($urandom_range(0, 20000)) - 10000);
		c = $itor($signed($urandom_range(0, 20000)) - 10000);
		n1 = $sqrt(a * a + b * b + c * c) + 1.0;
		p.fx = $rtoi(a / n1 * 16384.0);
		p.fy = $rtoi(b / n1 * 16384.0);
		p.fz = $rtoi(c / n1 * 16384.0);
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			p.tx = p.fx; p.ty = p.fy; p.tz = p.fz;
		end else if (sel == 1) begin
			p.tx = -p.fx; p.ty = -p.fy; p.tz = -p.fz;
		end else begin
			a = $itor($signed($urandom_range(0, 20000)) - 10000);
			b = $itor($signed($urandom_range(0, 20000)) - 10000);
			d = $itor($signed($urandom_range(0, 20000)) - 10000);
			n2 = $sqrt(a * a + b * b + d * d) + 1.0;
			p.tx = $rtoi(a / n2 * 16384.0);
			p.ty = $rtoi(b / n2 * 16384.0);
			p.tz = $rtoi(d / n2 * 16384.0);
		end
		return p;
	endfunction

	task automatic push_pair(input logic signed [15:0] fx, fy, fz, tx, ty, tz);
		vec_pair_t p;
		p.fx = fx; p.fy = fy; p.fz = fz;
		p.tx = tx; p.ty = ty; p.tz = tz;
		pending_pairs.push_back(p);
	endtask

	initial begin
		vec_pair_t p;
		errors = 0;
		stimulus_done = 1'b0;
		drain_request = 1'b0;
		push_pair(16384, 0, 0, 16384, 0, 0);
		push_pair(16384, 0, 0, -16384, 0, 0);
		push_pair(0, 16384, 0, 0, -16384, 0);
		push_pair(0, 0, 16384, 0, 0, -16384);
		push_pair(0, 0, -16384, 0, 0, 16384);
		push_pair(16384, 0, 0, 0, 16384, 0);
		push_pair(0, 16384, 0, 0, 0, 16384);
		push_pair(0, 0, 16384, 16384, 0, 0);
		push_pair(0, 0, 0, 0, 0, 0);
		push_pair(0, 0, 0, 16384, 0, 0);
		push_pair(11585, 11585, 0, -11585, -11585, 0);
		push_pair(9459, 9459, 9459, -9459, -9459, -9459);
		push_pair(-32768, -32768, -32768, 32767, 32767, 32767);
		push_pair(32767, -32768, 32767, -32768, 32767, -32768);
		push_pair(-16384, -16384, -16384, -16384, -16384, -16384);
		push_pair(32767, 32767, 32767, 32767, -32768, 0);
		push_pair(-1, -1, -1, 1, 1, 1);
		push_pair(1, 0, 0, 0, 1, 0);
		push_pair(16384, 0, 0, 11585, 11585, 0);
		push_pair(11585, 0, 11585, 0, 16384, 0);
		for (int i = 0; i < ITEMS; i++) begin
			if (i == ITEMS / 2) begin
				wait (pending_pairs.size() == 0);
				drain_request = 1'b1;
				wait (!s_tvalid && expected_matrices.size() == 0);
				drain_request = 1'b0;
			end
			if ($urandom_range(0, 4) == 0) begin
				p.fx = rand_comp(); p.fy = rand_comp(); p.fz = rand_comp();
				p.tx = rand_comp(); p.ty = rand_comp(); p.tz = rand_comp();
			end else
				p = unit_pair();
			pending_pairs.push_back(p);
		end
		stimulus_done = 1'b1;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else if (s_tvalid && !in_acc) begin
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_pairs.size() > 0 && !drain_request) begin
			s_tvalid <= 1'b1;
			s_tdata  <= pending_pairs.pop_front();
			send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		end else
			s_tvalid <= 1'b0;
	end

	always @(posedge clk) begin
		in_acc = arst_n && s_tvalid && s_tready;
		if (in_acc) begin
			expected_matrices.push_back(rotation_between(vec_pair_t'(s_tdata)));
			if (s_tdata[47:0] == s_tdata[95:48])
				same_dir_cnt++;
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready       <= 1'b0;
			recv_gap       <= 0;
			hold_count     <= 0;
			long_hold_done <= 1'b0;
		end else if (!long_hold_done && matrices_seen >= 100) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
			if (hold_count == HOLD_LONG)
				long_hold_done <= 1'b1;
		end else if (recv_gap > 0) begin
			m_tready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid && m_tready)
				recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		end
	end

	always @(posedge clk) begin
		matrix_t want;
		if (arst_n && m_tvalid && m_tready) begin
			matrices_seen++;
			if (expected_matrices.size() == 0) begin
				$error("unexpected output beat %h", m_tdata);
				errors++;
			end else begin
				want = expected_matrices.pop_front();
				for (int k = 0; k < 9; k++)
					if (m_tdata[16*k +: 16] != want[16*k +: 16]) begin
						$error("m%0d%0d expected %0d got %0d", k / 3, k % 3,
							$signed(want[16*k +: 16]), $signed(m_tdata[16*k +: 16]));
						errors++;
					end
			end
		end
	end

	initial begin
		matrices_seen = 0;
		same_dir_cnt = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!(stimulus_done && pending_pairs.size() == 0 && !s_tvalid
			&& expected_matrices.size() == 0) && cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= LIMIT) begin
			$display("timeout with %0d matrices outstanding", expected_matrices.size());
			$display("FAILURE");
			$finish;
		end else begin
			repeat (LAT + 20) @(posedge clk);
			if (expected_matrices.size() != 0)
				errors++;
			$display("checked %0d rotation matrices (%0d identical-vector pairs)",
				matrices_seen, same_dir_cnt);
			$display("including axis extremes, opposite pairs, zero and off-range vectors");
			if (errors == 0)
				$display("SUCCESS");
			else
				$display("FAILURE");
			$finish;
		end
	end

endmodule
